// ----- hw/rtl/led_pkg.sv -----
// ----------------------------------------------------------------------------
// Line editor package
// Shared types and character codes for the terminal line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package led_pkg;

    // Result action codes.
    typedef enum logic [1:0] {
        ACT_ECHO  = 2'd0,
        ACT_ERASE = 2'd1,
        ACT_BEEP  = 2'd2,
        ACT_END   = 2'd3
    } t_action;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPACE,
        ST_WORD,
        ST_DONE
    } t_state;

    // Shift command handed to every character cell.
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_op;

    // Keyboard codes.
    localparam logic [7:0] CH_KILL  = 8'h15;
    localparam logic [7:0] CH_WORD  = 8'h17;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_EOF   = 8'h04;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd126;

endpackage

`default_nettype wire

// ----- hw/rtl/led_rx_if.sv -----
// ----------------------------------------------------------------------------
// Line editor receive channel
// Carries one received keyboard byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface led_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_char;

    modport source (output valid, output rx_char, input ready);
    modport sink   (input valid, input rx_char, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/led_res_if.sv -----
// ----------------------------------------------------------------------------
// Line editor result channel
// Carries one editing action with its echo byte, erase count and line length.
// ----------------------------------------------------------------------------
`default_nettype none

interface led_res_if;
    logic              valid;
    logic              ready;
    led_pkg::t_action  action;
    logic [7:0]        echo_char;
    logic [5:0]        erase_count;
    logic [5:0]        line_length;

    modport source (output valid, output action, output echo_char,
                    output erase_count, output line_length, input ready);
    modport sink   (input valid, input action, input echo_char,
                    input erase_count, input line_length, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/led_cell.sv -----
// ----------------------------------------------------------------------------
// Line editor character cell
// One stage of the line stack: loads from its left neighbor on a push and
// from its right neighbor on a pop, holds otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module led_cell (
    input  wire logic              i_clk,
    input  wire led_pkg::t_cell_op i_op,
    input  wire logic [7:0]        i_push_char,
    input  wire logic [7:0]        i_pop_char,
    output logic [7:0]             o_char
);

    logic [7:0] r_char;

    // Character storage; contents below the cursor only are ever used.
    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_char <= i_push_char;
        end else if (i_op.pop) begin
            r_char <= i_pop_char;
        end
    end

    assign o_char = r_char;

endmodule

`default_nettype wire

// ----- hw/rtl/led_ctrl.sv -----
// ----------------------------------------------------------------------------
// Line editor controller
// Decodes each received byte, keeps the cursor, steers the cell chain and
// holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module led_ctrl #(
    parameter int LINE_CAPACITY = 40
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_rx_valid,
    output logic                    o_rx_ready,
    input  wire logic [7:0]         i_rx_char,
    output logic                    o_res_valid,
    input  wire logic               i_res_ready,
    output led_pkg::t_action        o_action,
    output logic [7:0]              o_echo_char,
    output logic [5:0]              o_erase_count,
    output logic [5:0]              o_line_length,
    output led_pkg::t_cell_op       o_cell_op,
    output logic [7:0]              o_push_char,
    input  wire logic [7:0]         i_tail_char
);

    localparam int CW = $clog2(LINE_CAPACITY + 1);

    led_pkg::t_state    r_state,  n_state;
    logic [CW-1:0]      r_cursor, n_cursor;
    logic [CW-1:0]      r_count,  n_count;
    logic               r_out_valid, n_out_valid;
    led_pkg::t_action   r_action, n_action;
    logic [7:0]         r_echo,   n_echo;
    logic [5:0]         r_erase,  n_erase;
    logic [5:0]         r_len,    n_len;
    logic               out_free;
    logic               rx_fire;
    logic               tail_space;
    logic               line_empty;

    // Result fields are six bits wide; wider counts wrap.
    function automatic logic [5:0] fit6(input logic [CW-1:0] v);
        logic [CW+5:0] ext;
        ext = {6'd0, v};
        return ext[5:0];
    endfunction

    assign out_free   = !r_out_valid || i_res_ready;
    assign o_rx_ready = (r_state == led_pkg::ST_IDLE) && out_free;
    assign rx_fire    = i_rx_valid && o_rx_ready;
    assign tail_space = (i_tail_char == led_pkg::CH_SPACE);
    assign line_empty = (r_cursor == '0);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= led_pkg::ST_IDLE;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_count  <= n_count;
        r_action <= n_action;
        r_echo   <= n_echo;
        r_erase  <= n_erase;
        r_len    <= n_len;
    end

    // Byte decode, word-erase scan and result loading.
    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_res_ready;
        n_action    = r_action;
        n_echo      = r_echo;
        n_erase     = r_erase;
        n_len       = r_len;
        o_cell_op   = '0;
        o_push_char = i_rx_char;

        case (r_state)
            led_pkg::ST_IDLE: begin
                if (rx_fire) begin
                    n_out_valid = 1'b1;
                    n_echo      = 8'd0;
                    n_erase     = 6'd0;
                    n_len       = fit6(r_cursor);
                    n_action    = led_pkg::ACT_BEEP;
                    case (i_rx_char)
                        led_pkg::CH_DEL: begin
                            if (!line_empty) begin
                                o_cell_op.pop = 1'b1;
                                n_cursor      = r_cursor - 1'b1;
                                n_action      = led_pkg::ACT_ERASE;
                                n_erase       = 6'd1;
                                n_len         = fit6(r_cursor - 1'b1);
                            end
                        end
                        led_pkg::CH_WORD: begin
                            // Result comes out once the scan finishes.
                            n_out_valid = r_out_valid && !i_res_ready;
                            n_action    = r_action;
                            n_echo      = r_echo;
                            n_erase     = r_erase;
                            n_len       = r_len;
                            n_count     = '0;
                            n_state     = led_pkg::ST_SPACE;
                        end
                        led_pkg::CH_KILL: begin
                            n_cursor = '0;
                            n_action = led_pkg::ACT_ERASE;
                            n_erase  = fit6(r_cursor);
                            n_len    = 6'd0;
                        end
                        led_pkg::CH_EOF: begin
                            if (line_empty) begin
                                n_action = led_pkg::ACT_END;
                            end
                        end
                        default: begin
                            if ((i_rx_char inside {[led_pkg::PRINT_LO:led_pkg::PRINT_HI]})
                                && (r_cursor < CW'(LINE_CAPACITY))) begin
                                o_cell_op.push = 1'b1;
                                n_cursor       = r_cursor + 1'b1;
                                n_action       = led_pkg::ACT_ECHO;
                                n_echo         = i_rx_char;
                                n_len          = fit6(r_cursor + 1'b1);
                            end
                        end
                    endcase
                end
            end
            led_pkg::ST_SPACE: begin
                // Drop trailing spaces one per cycle.
                if (!line_empty && tail_space) begin
                    o_cell_op.pop = 1'b1;
                    n_cursor      = r_cursor - 1'b1;
                    n_count       = r_count + 1'b1;
                end else begin
                    n_state = led_pkg::ST_WORD;
                end
            end
            led_pkg::ST_WORD: begin
                // Drop the word itself one character per cycle.
                if (!line_empty && !tail_space) begin
                    o_cell_op.pop = 1'b1;
                    n_cursor      = r_cursor - 1'b1;
                    n_count       = r_count + 1'b1;
                end else begin
                    n_state = led_pkg::ST_DONE;
                end
            end
            led_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_action    = led_pkg::ACT_ERASE;
                    n_echo      = 8'd0;
                    n_erase     = fit6(r_count);
                    n_len       = fit6(r_cursor);
                    n_state     = led_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = led_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_res_valid   = r_out_valid;
    assign o_action      = r_action;
    assign o_echo_char   = r_echo;
    assign o_erase_count = r_erase;
    assign o_line_length = r_len;

endmodule

`default_nettype wire

// ----- hw/rtl/line_edit_discipline.sv -----
// ----------------------------------------------------------------------------
// Terminal line editor
// Canonical line editing over a stack of character cells.
//
//   Channel   Direction  Fields
//   i_rx      in         rx_char
//   o_res     out        action, echo_char, erase_count, line_length
//
// Echo, single-character erase, line kill, end of input and beep are decoded
// as each request is taken, with the result registered. Word erase removes n
// characters (up to LINE_CAPACITY): the controller pops the cell stack
// one character per cycle while it tests the top cell. A result that is taken
// in the cycle of the next request frees the output register for it; a
// stalled result holds off the next request and the finish of a word erase.
// Synchronous reset empties the line.
// ----------------------------------------------------------------------------
`default_nettype none

module line_edit_discipline #(
    parameter int LINE_CAPACITY = 40
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    led_rx_if.sink      i_rx,
    led_res_if.source   o_res
);

    led_pkg::t_cell_op  cell_op;
    logic [7:0]         push_char;
    logic [7:0]         chars [LINE_CAPACITY];

    // Decode and sequencing.
    led_ctrl #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx.valid),
        .o_rx_ready    (i_rx.ready),
        .i_rx_char     (i_rx.rx_char),
        .o_res_valid   (o_res.valid),
        .i_res_ready   (o_res.ready),
        .o_action      (o_res.action),
        .o_echo_char   (o_res.echo_char),
        .o_erase_count (o_res.erase_count),
        .o_line_length (o_res.line_length),
        .o_cell_op     (cell_op),
        .o_push_char   (push_char),
        .i_tail_char   (chars[0])
    );

    // Cell chain: cell 0 holds the last character of the line.
    for (genvar k = 0; k < LINE_CAPACITY; k++) begin : g_cell
        logic [7:0] left_char;
        logic [7:0] right_char;

        if (k == 0) begin : g_head
            assign left_char = push_char;
        end else begin : g_body
            assign left_char = chars[k-1];
        end

        if (k == LINE_CAPACITY - 1) begin : g_end
            assign right_char = chars[k];
        end else begin : g_mid
            assign right_char = chars[k+1];
        end

        led_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (cell_op),
            .i_push_char (left_char),
            .i_pop_char  (right_char),
            .o_char      (chars[k])
        );
    end

endmodule

`default_nettype wire

// ----- hw/rtl/led_checker.sv -----
// ----------------------------------------------------------------------------
// Line editor checker
// Port-level properties of the line editor results.
// ----------------------------------------------------------------------------
`default_nettype none

module led_checker #(
    parameter int LINE_CAPACITY = 40
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_res_valid,
    input  wire logic              i_res_ready,
    input  wire led_pkg::t_action  i_action,
    input  wire logic [7:0]        i_echo_char,
    input  wire logic [5:0]        i_erase_count,
    input  wire logic [5:0]        i_line_length
);

    // A stalled result keeps its fields.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_action) && $stable(i_echo_char)
            && $stable(i_erase_count) && $stable(i_line_length))
        else $error("result changed while stalled");

    // An echo carries a printable byte and no erase count.
    a_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_action == led_pkg::ACT_ECHO |->
            i_echo_char >= led_pkg::PRINT_LO && i_echo_char <= led_pkg::PRINT_HI
            && i_erase_count == 6'd0 && i_line_length != 6'd0)
        else $error("bad echo result");

    // Beeps and end of input carry no echo byte and no erase count.
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_action == led_pkg::ACT_BEEP || i_action == led_pkg::ACT_END) |->
            i_echo_char == 8'd0 && i_erase_count == 6'd0)
        else $error("beep or end result with payload");

    // End of input is only reported on an empty line.
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_action == led_pkg::ACT_END |-> i_line_length == 6'd0)
        else $error("end of input on a non-empty line");

    // An erase never reports an echo byte.
    a_erase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_action == led_pkg::ACT_ERASE |-> i_echo_char == 8'd0)
        else $error("erase result with echo byte");

endmodule

bind line_edit_discipline led_checker #(
    .LINE_CAPACITY (LINE_CAPACITY)
) u_led_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_action      (o_res.action),
    .i_echo_char   (o_res.echo_char),
    .i_erase_count (o_res.erase_count),
    .i_line_length (o_res.line_length)
);

`default_nettype wire
